>>> rtl/hss_pkg.sv
// Package for the Horspool string search unit.
// Holds shared constants, the request action codes and the controller/datapath structs.
// Depends on nothing; every other file in the project depends on it.
package hss_pkg;

    localparam int TEXT_MAX_DEF    = 256;
    localparam int PATTERN_MAX_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 14;

    // Every byte value has its own entry in the bad-character table.
    localparam int ALPHABET = 256;
    localparam int ALPHA_W  = $clog2(ALPHABET);

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_PATTERN = 2'd1,
        ACT_TEXT    = 2'd2,
        ACT_SEARCH  = 2'd3
    } action_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load_pat;
        logic load_txt;
        logic start;
        logic fill_wr;
        logic prep_rd;
        logic prep_wr;
        logic scan_init;
        logic cmp_rd;
        logic cmp_match;
        logic set_hit;
        logic set_empty;
        logic txt_rd_end;
        logic shf_rd;
        logic shift_add;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pat_empty;
        logic fill_last;
        logic prep_done;
        logic m_gt_n;
        logic bytes_eq;
        logic k_last;
        logic end_in_range;
        logic out_free;
    } status_t;

endpackage

>>> rtl/hss_if.sv
// Handshake interfaces for the request and result channels of the search unit.
// Depends on hss_pkg for the payload widths.
interface hss_request_if;
    logic                         valid;
    logic                         ready;
    logic [hss_pkg::ACTION_W-1:0] action;
    logic [hss_pkg::BYTE_W-1:0]   byte_in;

    modport source (output valid, output action, output byte_in, input ready);
    modport sink   (input valid, input action, input byte_in, output ready);
endinterface

interface hss_result_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [hss_pkg::POS_W-1:0]   match_position;
    logic [hss_pkg::COUNT_W-1:0] comparison_count;
    logic                        overflowed;

    modport source (output valid, output found, output match_position,
                    output comparison_count, output overflowed, input ready);
    modport sink   (input valid, input found, input match_position,
                    input comparison_count, input overflowed, output ready);
endinterface

>>> rtl/horspool_string_search_unit.sv
// Top level of the Horspool string search unit.
// Depends on hss_pkg, hss_if, hss_ctrl and hss_datapath.
//
// The request channel carries one transaction per action: clear both stores,
// append a pattern byte, append a text byte, or run a search. Clear and append
// transactions are taken one per cycle and produce no result. Bytes beyond the
// capacity of a store are dropped and set the overflow flag until the next clear.
// A search transaction produces exactly one transaction on the result channel.
// Its duration is set by the single-ported shift-table memory and the
// one-read-per-cycle pattern and text memories: every table entry is preset,
// each pattern byte but the last enters its shift with a read and a write,
// each byte comparison takes a read and an evaluation and each shift a table read
// and an add, around the accepting cycle, the start of the scan and the result load.
// No request is taken while a search runs. The result sits in an output
// register; if the receiver stalls, further clear and append transactions are
// still accepted, and a new search waits at its end until the register is free.
// Reset empties both stores, clears the overflow flag and drops any pending
// result; store contents are not cleared.
module horspool_string_search_unit #(
    parameter int TEXT_MAX    = hss_pkg::TEXT_MAX_DEF,
    parameter int PATTERN_MAX = hss_pkg::PATTERN_MAX_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    hss_request_if.sink  request,
    hss_result_if.source result
);

    // Commands and status are the only link between the two halves.
    hss_pkg::cmd_t    cmd;
    hss_pkg::status_t status;

    hss_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (request.valid),
        .req_action (request.action),
        .req_ready  (request.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // The datapath owns all three memories and drives the result channel.
    hss_datapath #(
        .TEXT_MAX    (TEXT_MAX),
        .PATTERN_MAX (PATTERN_MAX)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (request.byte_in),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

endmodule

>>> rtl/hss_ctrl.sv
// Controller state machine of the Horspool search unit.
// Depends on hss_pkg for the action codes and the command and status structs.
module hss_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic [hss_pkg::ACTION_W-1:0] req_action,
    output logic                         req_ready,
    input  hss_pkg::status_t             status,
    output hss_pkg::cmd_t                cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_PREP_RD,
        S_PREP_WR,
        S_CMP_RD,
        S_CMP_EV,
        S_SHF_TAB,
        S_SHF_ADD,
        S_FINISH
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    hss_pkg::action_t act;

    assign act       = hss_pkg::action_t'(req_action);
    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (act)
                        hss_pkg::ACT_CLEAR:   cmd.clear    = 1'b1;
                        hss_pkg::ACT_PATTERN: cmd.load_pat = 1'b1;
                        hss_pkg::ACT_TEXT:    cmd.load_txt = 1'b1;
                        hss_pkg::ACT_SEARCH:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_FILL;
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                cmd.fill_wr = 1'b1;
                if (status.fill_last)
                begin
                    if (status.pat_empty)
                    begin
                        cmd.set_empty = 1'b1;
                        state_next    = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_PREP_RD;
                    end
                end
            end
            S_PREP_RD:
            begin
                if (status.prep_done)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = status.m_gt_n ? S_FINISH : S_CMP_RD;
                end
                else
                begin
                    cmd.prep_rd = 1'b1;
                    state_next  = S_PREP_WR;
                end
            end
            S_PREP_WR:
            begin
                cmd.prep_wr = 1'b1;
                state_next  = S_PREP_RD;
            end
            S_CMP_RD:
            begin
                cmd.cmp_rd = 1'b1;
                state_next = S_CMP_EV;
            end
            S_CMP_EV:
            begin
                if (status.bytes_eq)
                begin
                    cmd.cmp_match = 1'b1;
                    if (status.k_last)
                    begin
                        cmd.set_hit = 1'b1;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_CMP_RD;
                    end
                end
                else
                begin
                    cmd.txt_rd_end = 1'b1;
                    state_next     = S_SHF_TAB;
                end
            end
            S_SHF_TAB:
            begin
                cmd.shf_rd = 1'b1;
                state_next = S_SHF_ADD;
            end
            S_SHF_ADD:
            begin
                cmd.shift_add = 1'b1;
                state_next    = status.end_in_range ? S_CMP_RD : S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/hss_datapath.sv
// Datapath of the Horspool search unit: pattern, text and shift memories,
// the scan counters and the result register. Depends on hss_pkg and hss_result_if.
module hss_datapath #(
    parameter int TEXT_MAX    = hss_pkg::TEXT_MAX_DEF,
    parameter int PATTERN_MAX = hss_pkg::PATTERN_MAX_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [hss_pkg::BYTE_W-1:0] byte_in,
    input  hss_pkg::cmd_t              cmd,
    output hss_pkg::status_t           status,
    hss_result_if.source               result
);

    localparam int PIW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int PLW = $clog2(PATTERN_MAX + 1);
    localparam int TIW = $clog2(TEXT_MAX);
    localparam int TLW = $clog2(TEXT_MAX + 1);
    localparam int EW  = $clog2(TEXT_MAX + PATTERN_MAX + 1);
    localparam int BW  = hss_pkg::BYTE_W;
    localparam int CW  = hss_pkg::COUNT_W;
    localparam int PW  = hss_pkg::POS_W;
    localparam int AW  = hss_pkg::ALPHA_W;

    // Memories.
    logic [BW-1:0]  pat_mem [PATTERN_MAX];
    logic [BW-1:0]  txt_mem [TEXT_MAX];
    logic [PLW-1:0] shf_mem [hss_pkg::ALPHABET];

    logic [BW-1:0]  pat_rd_data_reg;
    logic [BW-1:0]  txt_rd_data_reg;
    logic [PLW-1:0] shf_rd_data_reg;

    // Lengths and flags.
    logic [PLW-1:0] plen_reg;
    logic [TLW-1:0] tlen_reg;
    logic           ovf_reg;

    // Search state.
    logic [AW-1:0]  idx_reg;
    logic [PLW-1:0] j_reg;
    logic [PLW-1:0] k_reg;
    logic [EW-1:0]  end_reg;
    logic [CW-1:0]  count_reg;
    logic           found_reg;
    logic [PW-1:0]  pos_reg;

    // Result register.
    logic           out_valid_reg;
    logic           out_found_reg;
    logic [PW-1:0]  out_pos_reg;
    logic [CW-1:0]  out_count_reg;
    logic           out_ovf_reg;

    logic           pat_full;
    logic           txt_full;
    logic [EW-1:0]  m_ext;
    logic [EW-1:0]  n_ext;
    logic [EW-1:0]  k_ext;
    logic [EW-1:0]  end_next;
    logic [PLW-1:0] pat_addr_full;
    logic [EW-1:0]  txt_addr_full;
    logic           pat_re;
    logic           txt_re;
    logic [EW+PW-1:0] pos_wide;
    logic [CW-1:0]  count_bumped;

    assign pat_full = (plen_reg == PLW'(PATTERN_MAX));
    assign txt_full = (tlen_reg == TLW'(TEXT_MAX));
    assign m_ext    = EW'(plen_reg);
    assign n_ext    = EW'(tlen_reg);
    assign k_ext    = EW'(k_reg);
    assign end_next = end_reg + EW'(shf_rd_data_reg);
    assign pos_wide = (EW+PW)'(end_reg) - (EW+PW)'(plen_reg) + (EW+PW)'(1);
    assign count_bumped = (count_reg == '1) ? count_reg : count_reg + CW'(1);

    // Pattern is read by index j while building the table, and right to left while scanning.
    assign pat_addr_full = cmd.prep_rd ? j_reg : (plen_reg - PLW'(1) - k_reg);
    assign txt_addr_full = cmd.txt_rd_end ? end_reg : (end_reg - k_ext);
    assign pat_re        = cmd.prep_rd | cmd.cmp_rd;
    assign txt_re        = cmd.cmp_rd | cmd.txt_rd_end;

    always_comb
    begin
        status.pat_empty    = (plen_reg == '0);
        status.fill_last    = (idx_reg == '1);
        status.prep_done    = ({1'b0, j_reg} + (PLW+1)'(1)) >= {1'b0, plen_reg};
        status.m_gt_n       = (m_ext > n_ext);
        status.bytes_eq     = (pat_rd_data_reg == txt_rd_data_reg);
        status.k_last       = ({1'b0, k_reg} + (PLW+1)'(1)) == {1'b0, plen_reg};
        status.end_in_range = (end_next < n_ext);
        status.out_free     = !out_valid_reg || result.ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pat && !pat_full)
        begin
            pat_mem[plen_reg[PIW-1:0]] <= byte_in;
        end
        if (pat_re)
        begin
            pat_rd_data_reg <= pat_mem[pat_addr_full[PIW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_txt && !txt_full)
        begin
            txt_mem[tlen_reg[TIW-1:0]] <= byte_in;
        end
        if (txt_re)
        begin
            txt_rd_data_reg <= txt_mem[txt_addr_full[TIW-1:0]];
        end
    end

    // Every entry is first set to the pattern length; later pattern positions
    // then overwrite earlier ones, so the rightmost occurrence wins.
    always_ff @(posedge clk)
    begin
        priority if (cmd.fill_wr)
        begin
            shf_mem[idx_reg] <= plen_reg;
        end
        else if (cmd.prep_wr)
        begin
            shf_mem[pat_rd_data_reg] <= plen_reg - j_reg - PLW'(1);
        end
        if (cmd.shf_rd)
        begin
            shf_rd_data_reg <= shf_mem[txt_rd_data_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= '0;
            tlen_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            priority if (cmd.clear)
            begin
                plen_reg <= '0;
                tlen_reg <= '0;
                ovf_reg  <= 1'b0;
            end
            else if (cmd.load_pat)
            begin
                if (pat_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    plen_reg <= plen_reg + PLW'(1);
                end
            end
            else if (cmd.load_txt)
            begin
                if (txt_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    tlen_reg <= tlen_reg + TLW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            idx_reg   <= '0;
            j_reg     <= '0;
            count_reg <= '0;
            found_reg <= 1'b0;
            pos_reg   <= '0;
        end
        if (cmd.fill_wr)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
        if (cmd.prep_wr)
        begin
            j_reg <= j_reg + PLW'(1);
        end
        if (cmd.set_empty)
        begin
            found_reg <= 1'b1;
        end
        priority if (cmd.scan_init)
        begin
            end_reg <= m_ext - EW'(1);
            k_reg   <= '0;
        end
        else if (cmd.cmp_match)
        begin
            k_reg     <= k_reg + PLW'(1);
            count_reg <= count_bumped;
        end
        else if (cmd.shift_add)
        begin
            end_reg   <= end_next;
            k_reg     <= '0;
            count_reg <= count_bumped;
        end
        if (cmd.set_hit)
        begin
            found_reg <= 1'b1;
            pos_reg   <= pos_wide[PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_found_reg <= found_reg;
            out_pos_reg   <= pos_reg;
            out_count_reg <= count_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.found            = out_found_reg;
    assign result.match_position   = out_pos_reg;
    assign result.comparison_count = out_count_reg;
    assign result.overflowed       = out_ovf_reg;

endmodule

>>> rtl/hss_checker.sv
// Port-level checker for the Horspool search unit, and its bind to the top level.
// Depends on hss_pkg for the action codes.
module hss_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic [hss_pkg::ACTION_W-1:0] req_action,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic                         res_found,
    input logic [hss_pkg::POS_W-1:0]    res_pos,
    input logic [hss_pkg::COUNT_W-1:0]  res_count,
    input logic                         res_ovf
);

    logic req_acc;
    assign req_acc = req_valid && req_ready;

    // A stalled result transaction holds its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_found) && $stable(res_pos)
            && $stable(res_count) && $stable(res_ovf))
        else $error("result changed while stalled");

    // A search occupies the unit, so the next cycle takes no request.
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && (req_action == hss_pkg::ACT_SEARCH) |=> !req_ready)
        else $error("request taken right after a search started");

    // A clear or append leaves the unit ready again in the next cycle.
    a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && (req_action != hss_pkg::ACT_SEARCH) |=> req_ready)
        else $error("unit busy after a load transaction");

    // A miss reports position zero.
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_found |-> res_pos == '0)
        else $error("non-zero position on a miss");

endmodule

bind horspool_string_search_unit hss_checker u_hss_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (request.valid),
    .req_ready  (request.ready),
    .req_action (request.action),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_found  (result.found),
    .res_pos    (result.match_position),
    .res_count  (result.comparison_count),
    .res_ovf    (result.overflowed)
);
